// ===== design/bacm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bacm_pkg;

  localparam int SampleW     = 12;
  localparam int ValueW      = 14;
  localparam int CfgW        = 2;
  localparam int OffW        = 13;
  localparam int CurveW      = 13;
  localparam int CurvePoints = 33;
  localparam int CurveCnt    = 3;
  localparam int CurveIdxW   = 6;
  localparam int FracW       = 6;
  localparam int RampW       = 8;
  localparam int MulW        = 13;
  localparam int AccW        = 19;

  localparam int TestPeriodDef = 80;

  typedef logic signed [OffW-1:0] offset_t;

  localparam offset_t DeadRange  = 13'sd20;
  localparam offset_t SmallRange = 13'sd200;

  localparam logic [RampW-1:0]   RampStep  = 8'd8;
  localparam logic [SampleW-1:0] ZeroReset = 12'd2048;
  localparam logic [SampleW-1:0] ZeroMax   = 12'd4095;
  localparam logic [MulW-1:0]    Gain      = 13'd4540;
  localparam logic [2*MulW-1:0]  ClipLimit = 26'(2047 * 4096);
  localparam logic [ValueW-1:0]  Center    = 14'd8000;
  localparam logic [AccW-1:0]    CenterAcc = 19'(8000 * 64);
  localparam logic [FracW:0]     FracOne   = 7'd64;

  // Curve codes
  localparam logic [CfgW-1:0] CurveLinear   = 2'd0;
  localparam logic [CfgW-1:0] CurveHalfCube = 2'd1;
  localparam logic [CfgW-1:0] CurveFullCube = 2'd2;
  localparam logic [CfgW-1:0] CurveUnused   = 2'd3;

  typedef logic [CurveCnt-1:0][CurvePoints-1:0][CurveW-1:0] curve_rom_t;

  function automatic curve_rom_t build_curve_rom();
    curve_rom_t  rom;
    int unsigned n;
    rom = '0;
    for (int i = 0; i < CurvePoints; i++) begin
      n = unsigned'(i);
      rom[0][i] = CurveW'(250 * n);
      rom[1][i] = CurveW'((250 * n * (1024 + n * n)) >> 11);
      rom[2][i] = CurveW'((250 * n * n * n) >> 10);
    end
    return rom;
  endfunction

  localparam curve_rom_t CurveRom = build_curve_rom();

endpackage

`default_nettype wire

// ===== design/bacm_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bacm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [bacm_pkg::SampleW-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

// ===== design/bacm_value_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bacm_value_if;
  logic                        valid;
  logic                        ready;
  logic [bacm_pkg::ValueW-1:0] control_value;

  modport source (output valid, output control_value, input ready);
  modport sink (input valid, input control_value, output ready);
endinterface

`default_nettype wire

// ===== design/bender_autozero_curve_mapper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Samples: a new sample is accepted only in the idle state. An interpolated value passes the
//   scale, low, high and emit states, a clipped one scale and emit, a return to center emit;
//   a sample with no result stays idle. These are set by the shared 13x13 multiplier, and
//   emit holds on output stalls. Emit loads the result into the output register.
// Reset (async, active low): zero level 2048, curve 1 (half cubic), tracking state cleared,
//   output register empty.
module bender_autozero_curve_mapper_unit #(
  parameter int TestPeriod = bacm_pkg::TestPeriodDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [bacm_pkg::CfgW-1:0]   cfg_data_i,
  bacm_sample_if.sink                sample_i,
  bacm_value_if.source               value_o
);

  localparam int CntW = $clog2(TestPeriod + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(TestPeriod);

  // Sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScale = 3'd1;
  localparam logic [2:0] StLow   = 3'd2;
  localparam logic [2:0] StHigh  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration and auto-zero tracking
  logic [bacm_pkg::CfgW-1:0]    sel_q, sel_d;
  logic [bacm_pkg::SampleW-1:0] zero_q, zero_d;
  bacm_pkg::offset_t            last_q, last_d;
  logic                         small_q, small_d;
  logic                         test_q, test_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         ramp_q, ramp_d;
  logic [bacm_pkg::RampW-1:0]   rem_q, rem_d;
  logic                         up_q, up_d;

  // Per-sample working registers
  logic                          neg_q, neg_d;
  logic [bacm_pkg::SampleW-1:0]  mag_q, mag_d;
  logic [bacm_pkg::FracW-1:0]    frac_q, frac_d;
  logic [4:0]                    idx_q, idx_d;
  logic [bacm_pkg::AccW-1:0]     acc_q, acc_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [bacm_pkg::ValueW-1:0] out_value_q, out_value_d;

  logic                          accept;
  bacm_pkg::offset_t             off;
  bacm_pkg::offset_t             pos_mag;
  bacm_pkg::offset_t             neg_mag;
  bacm_pkg::offset_t             abs_off;
  logic                          in_small;
  logic                          last_live;
  logic [bacm_pkg::SampleW:0]    zero_up;
  logic [bacm_pkg::MulW-1:0]     mul_a, mul_b;
  logic [2*bacm_pkg::MulW-1:0]   mul_p;
  logic [bacm_pkg::CurveIdxW-1:0] idx_lo, idx_hi;
  logic [bacm_pkg::CurveW-1:0]   mapped;

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == StIdle);
  assign value_o.valid         = out_valid_q;
  assign value_o.control_value = out_value_q;

  // Signed offset of the sample from the tracked zero
  assign off      = $signed({1'b0, sample_i.raw_sample}) - $signed({1'b0, zero_q});
  assign pos_mag  = off - bacm_pkg::DeadRange;
  assign neg_mag  = -bacm_pkg::DeadRange - off;
  assign abs_off  = (off > 13'sd0) ? off : -off;
  assign in_small = (off > -bacm_pkg::SmallRange) && (off < bacm_pkg::SmallRange);
  assign last_live = (last_q > bacm_pkg::DeadRange) || (last_q < -bacm_pkg::DeadRange);
  assign zero_up  = {1'b0, zero_q} + {5'd0, bacm_pkg::RampStep};

  assign idx_lo = {1'b0, idx_q};
  assign idx_hi = idx_lo + 6'd1;
  assign mapped = acc_q[bacm_pkg::AccW-1:bacm_pkg::FracW];

  // Shared multiplier: gain scaling, then the two interpolation weights
  always_comb begin
    unique case (state_q)
      StScale: begin
        mul_a = {1'b0, mag_q};
        mul_b = bacm_pkg::Gain;
      end
      StLow: begin
        mul_a = bacm_pkg::CurveRom[sel_q][idx_lo];
        mul_b = {6'd0, bacm_pkg::FracOne - {1'b0, frac_q}};
      end
      StHigh: begin
        mul_a = bacm_pkg::CurveRom[sel_q][idx_hi];
        mul_b = {7'd0, frac_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Auto-zero tracking: advance once per accepted sample
  always_comb begin
    small_d = small_q;
    test_d  = test_q;
    cnt_d   = cnt_q;
    ramp_d  = ramp_q;
    rem_d   = rem_q;
    up_d    = up_q;
    zero_d  = zero_q;
    if (accept) begin
      small_d = in_small;
      if (in_small && !small_q) begin
        cnt_d  = '0;
        test_d = 1'b1;
      end else if (!in_small && small_q) begin
        test_d = 1'b0;
      end
      if (test_d) begin
        if (cnt_d < CntLast) begin
          cnt_d = cnt_d + CntW'(1);
        end else begin
          // Offset held small long enough: start a ramp toward it
          test_d = 1'b0;
          ramp_d = 1'b1;
          rem_d  = abs_off[bacm_pkg::RampW-1:0];
          up_d   = (off > 13'sd0);
        end
      end
      if (ramp_d) begin
        if (rem_d <= bacm_pkg::RampStep) begin
          rem_d  = '0;
          ramp_d = 1'b0;
        end else begin
          rem_d = rem_d - bacm_pkg::RampStep;
          if (up_d) begin
            zero_d = zero_up[bacm_pkg::SampleW] ? bacm_pkg::ZeroMax
                                                : zero_up[bacm_pkg::SampleW-1:0];
          end else begin
            zero_d = (zero_q < {4'd0, bacm_pkg::RampStep}) ? '0
                     : zero_q - {4'd0, bacm_pkg::RampStep};
          end
        end
      end
    end
  end

  // Sequencer and output register
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    frac_d      = frac_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !value_o.ready;
    sel_d       = sel_q;

    if (cfg_we_i && (cfg_data_i != bacm_pkg::CurveUnused)) begin
      sel_d = cfg_data_i;
    end

    unique case (state_q)
      StIdle: begin
        if (accept && (off != last_q)) begin
          last_d = off;
          if (off > bacm_pkg::DeadRange) begin
            mag_d   = pos_mag[bacm_pkg::SampleW-1:0];
            neg_d   = 1'b0;
            state_d = StScale;
          end else if (off < -bacm_pkg::DeadRange) begin
            mag_d   = neg_mag[bacm_pkg::SampleW-1:0];
            neg_d   = 1'b1;
            state_d = StScale;
          end else if (last_live) begin
            // Back into the dead range: emit center
            acc_d   = '0;
            neg_d   = 1'b0;
            state_d = StEmit;
          end
        end
      end
      StScale: begin
        if (mul_p > bacm_pkg::ClipLimit) begin
          acc_d   = bacm_pkg::CenterAcc;
          state_d = StEmit;
        end else begin
          frac_d  = mul_p[17:12];
          idx_d   = mul_p[22:18];
          state_d = StLow;
        end
      end
      StLow: begin
        acc_d   = mul_p[bacm_pkg::AccW-1:0];
        state_d = StHigh;
      end
      StHigh: begin
        acc_d   = acc_q + mul_p[bacm_pkg::AccW-1:0];
        state_d = StEmit;
      end
      StEmit: begin
        // Hold until the output register is free or being drained
        if (!out_valid_q || value_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = neg_q ? bacm_pkg::Center - {1'b0, mapped}
                              : bacm_pkg::Center + {1'b0, mapped};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= bacm_pkg::CurveHalfCube;
      zero_q      <= bacm_pkg::ZeroReset;
      last_q      <= '0;
      small_q     <= 1'b0;
      test_q      <= 1'b0;
      cnt_q       <= '0;
      ramp_q      <= 1'b0;
      rem_q       <= '0;
      up_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      zero_q      <= zero_d;
      last_q      <= last_d;
      small_q     <= small_d;
      test_q      <= test_d;
      cnt_q       <= cnt_d;
      ramp_q      <= ramp_d;
      rem_q       <= rem_d;
      up_q        <= up_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q       <= neg_d;
    mag_q       <= mag_d;
    frac_q      <= frac_d;
    idx_q       <= idx_d;
    acc_q       <= acc_d;
    out_value_q <= out_value_d;
  end

endmodule

`default_nettype wire
